FILE: design/i2cws_pkg.sv
// Shared types and constants for the I2C write transaction serializer.
package i2cws_pkg;

  localparam logic [7:0] CTRL_DATA = 8'h40;
  localparam logic [7:0] CTRL_CMD  = 8'h00;

  // Sub-step positions inside one byte: 16 data half-clocks, then the ack clock.
  localparam logic [4:0] SUB_ACK_HI = 5'd16;
  localparam logic [4:0] SUB_ACK_LO = 5'd17;
  localparam logic [4:0] SUB_START_END = 5'd2;
  localparam logic [4:0] SUB_STOP_END  = 5'd1;
  localparam logic [1:0] BYTE_LAST = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] payload;
  } frame_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_BYTE  = 3'b010,
    PH_STOP  = 3'b100
  } phase_t;

endpackage

FILE: design/i2cws_front.sv
// Input stage: registers one transaction and builds its three-byte frame.
module i2cws_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            dev_addr,
  input  logic                  is_data,
  input  logic [7:0]            payload,
  input  i2cws_pkg::queue_status_t q_status,
  output logic                  push,
  output i2cws_pkg::frame_t     push_frame
);
  import i2cws_pkg::*;

  logic   fv;
  frame_t fr;

  assign push       = fv && !q_status.full;
  assign in_ready   = !fv || !q_status.full;
  assign push_frame = fr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  // Select the control byte from the data/command flag.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr.addr    <= dev_addr;
      fr.ctrl    <= is_data ? CTRL_DATA : CTRL_CMD;
      fr.payload <= payload;
    end
  end

endmodule

FILE: design/i2cws_queue.sv
// Two-entry frame queue between the input stage and the bus sequencer.
module i2cws_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  i2cws_pkg::frame_t         push_frame,
  input  logic                      pop,
  output i2cws_pkg::frame_t         pop_frame,
  output i2cws_pkg::queue_status_t  status
);
  import i2cws_pkg::*;

  frame_t     mem [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'(QUEUE_DEPTH));
  assign pop_frame    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: design/i2cws_back.sv
// Bus sequencer: expands one frame into 59 SCL/SDA states behind an output register.
module i2cws_back (
  input  logic                      clk,
  input  logic                      rst,
  input  i2cws_pkg::frame_t         frame,
  input  logic                      frame_valid,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      scl,
  output logic                      sda,
  output logic                      hold,
  output logic                      last
);
  import i2cws_pkg::*;

  logic        busy;
  phase_t      phase;
  logic [4:0]  sub;
  logic [1:0]  byte_idx;
  logic [23:0] shreg;

  logic cur_scl, cur_sda, cur_hold, cur_last, final_step;
  logic advance;

  assign advance = busy && (!out_valid || out_ready);
  assign pop     = frame_valid && (!busy || (advance && final_step));

  always_comb begin
    cur_scl    = 1'b1;
    cur_sda    = 1'b1;
    cur_hold   = 1'b1;
    cur_last   = 1'b0;
    final_step = 1'b0;
    unique case (phase)
      PH_START: begin
        cur_scl  = (sub != SUB_START_END);
        cur_sda  = (sub == 5'd0);
        cur_hold = (sub != SUB_START_END);
      end
      PH_BYTE: begin
        if (sub == SUB_ACK_HI) begin
          cur_scl = 1'b1;
        end else if (sub == SUB_ACK_LO) begin
          cur_scl  = 1'b0;
          cur_hold = 1'b0;
        end else begin
          cur_scl = ~sub[0];
          cur_sda = shreg[23];
        end
      end
      PH_STOP: begin
        cur_sda    = (sub == SUB_STOP_END);
        cur_last   = (sub == SUB_STOP_END);
        final_step = (sub == SUB_STOP_END);
      end
      default: begin
        cur_scl = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      phase    <= PH_START;
      sub      <= 5'd0;
      byte_idx <= 2'd0;
    end else if (pop) begin
      busy     <= 1'b1;
      phase    <= PH_START;
      sub      <= 5'd0;
      byte_idx <= 2'd0;
    end else if (advance) begin
      unique case (phase)
        PH_START: begin
          if (sub == SUB_START_END) begin
            phase <= PH_BYTE;
            sub   <= 5'd0;
          end else begin
            sub <= sub + 5'd1;
          end
        end
        PH_BYTE: begin
          if (sub == SUB_ACK_LO) begin
            sub <= 5'd0;
            if (byte_idx == BYTE_LAST) begin
              phase <= PH_STOP;
            end else begin
              byte_idx <= byte_idx + 2'd1;
            end
          end else begin
            sub <= sub + 5'd1;
          end
        end
        PH_STOP: begin
          if (final_step) begin
            busy <= 1'b0;
          end else begin
            sub <= sub + 5'd1;
          end
        end
        default: begin
          phase <= PH_START;
        end
      endcase
    end
  end

  // Shift the next data bit to the top after each low half-clock.
  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= frame;
    end else if (advance && (phase == PH_BYTE) && (sub < SUB_ACK_HI) && sub[0]) begin
      shreg <= {shreg[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scl  <= cur_scl;
      sda  <= cur_sda;
      hold <= cur_hold;
      last <= cur_last;
    end
  end

  a_pop_needs_frame: assert property (@(posedge clk) disable iff (rst)
    pop |-> frame_valid)
    else $error("pop from empty queue");

  a_last_on_stop: assert property (@(posedge clk) disable iff (rst)
    (advance && final_step) |=> (out_valid && last))
    else $error("stop state not flagged last");

  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((sub <= SUB_ACK_LO) && (byte_idx <= BYTE_LAST)))
    else $error("sequencer counter out of range");

  a_no_pop_midframe: assert property (@(posedge clk) disable iff (rst)
    (busy && !(advance && final_step)) |-> !pop)
    else $error("new frame loaded mid-transaction");

endmodule

FILE: design/i2c_write_transaction_serializer_top.sv
// Top level of the I2C write transaction serializer.
//
// Input channel (in_valid/in_ready): one item is one three-byte I2C write:
// dev_addr (address byte with R/W), is_data (control byte 0x40 when set,
// 0x00 when clear) and payload (third byte).
// Output channel (out_valid/out_ready): one item per bus state, giving the
// scl and sda levels, hold (state lasts one delay period) and last (stop
// complete). Every transaction yields exactly 59 states: start (3), three
// bytes of 8 bits MSB first plus an unsampled ack clock (18 each), stop (2).
//
// With an idle pipeline, an accepted item is written to the queue, loaded
// by the sequencer and then registered at the output, where out_valid rises
// with the first state. Throughput: the sequencer emits one state per cycle
// while the receiver takes them; it loads the next frame on the
// cycle of the final stop state, so back-to-back transactions leave no gap.
// A two-entry queue plus the input register let up to three further items
// be taken while a transaction is still being emitted.
//
// Reset (rst, synchronous, active high) empties the input register and the
// queue and idles the sequencer. When the receiver stalls, the output
// register holds its state and the sequencer freezes; input items keep
// being taken until the queue and the input register fill up.
module i2c_write_transaction_serializer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] dev_addr,
  input  logic       is_data,
  input  logic [7:0] payload,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl,
  output logic       sda,
  output logic       hold,
  output logic       last
);
  import i2cws_pkg::*;

  queue_status_t q_status;
  logic          push;
  logic          pop;
  frame_t        push_frame;
  frame_t        pop_frame;

  // Accept items and build the address/control/payload frame.
  i2cws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dev_addr   (dev_addr),
    .is_data    (is_data),
    .payload    (payload),
    .q_status   (q_status),
    .push       (push),
    .push_frame (push_frame)
  );

  // Decouple intake from bus sequencing.
  i2cws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (q_status)
  );

  // Expand each frame into bus states.
  i2cws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame       (pop_frame),
    .frame_valid (q_status.valid),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl         (scl),
    .sda         (sda),
    .hold        (hold),
    .last        (last)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the I2C write transaction serializer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cws_pkg::*;

  // One write always expands to start (3), three bytes of 18 states, stop (2).
  localparam int STATES_PER_WRITE = 59;
  localparam int RANDOM_WRITES    = 360;
  localparam int DRAIN_CYCLES     = 20;    // margin after the last owed state
  localparam int WATCHDOG_LIMIT   = 1000;  // cycles with no item moving
  localparam int REPORT_LIMIT     = 10;
  localparam int N_DIRECTED       = 16;

  // One bus state as seen on the output channel.
  typedef struct packed {
    logic scl;
    logic sda;
    logic hold;
    logic last;
  } bus_state_t;

  // A directed write. Where has_wire is set, wire_bytes holds the three bytes
  // expected on the bus (address, control, payload) as typed in by hand.
  typedef struct packed {
    logic [7:0]  addr;
    logic        is_data;
    logic [7:0]  payload;
    logic        has_wire;
    logic [23:0] wire_bytes;
  } write_row_t;

  // Receiver stall styles; the receiver hops between them on its own.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCKS
  } rx_style_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] dev_addr = 8'h00;
  logic       is_data = 1'b0;
  logic [7:0] payload = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl;
  logic       sda;
  logic       hold;
  logic       last;

  bus_state_t pending_states[$];   // bus states still owed by the block
  int         mismatch_count = 0;
  int         states_seen = 0;
  int         burst_left = 0;
  write_row_t directed_rows [N_DIRECTED];

  i2c_write_transaction_serializer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dev_addr  (dev_addr),
    .is_data   (is_data),
    .payload   (payload),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl       (scl),
    .sda       (sda),
    .hold      (hold),
    .last      (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Control byte that goes on the wire for a given is_data flag.
  function automatic logic [7:0] wire_control_byte(input logic sel_data);
    return sel_data ? CTRL_DATA : CTRL_CMD;
  endfunction

  // Append one bus state to the expectation queue.
  function automatic void owe_state(input logic c, input logic d, input logic h,
                                    input logic l);
    bus_state_t s;
    s.scl  = c;
    s.sda  = d;
    s.hold = h;
    s.last = l;
    pending_states.push_back(s);
  endfunction

  // Expand one write into its full bus-state sequence.
  function automatic void expand_write(input logic [7:0] addr_byte,
                                       input logic [7:0] ctrl_byte,
                                       input logic [7:0] data_byte);
    logic [7:0] bytes [3];
    bytes[0] = addr_byte;
    bytes[1] = ctrl_byte;
    bytes[2] = data_byte;
    // Start: SDA falls while SCL is high, then SCL drops.
    owe_state(1'b1, 1'b1, 1'b1, 1'b0);
    owe_state(1'b1, 1'b0, 1'b1, 1'b0);
    owe_state(1'b0, 1'b0, 1'b0, 1'b0);
    foreach (bytes[b]) begin
      for (int k = 7; k >= 0; k--) begin
        owe_state(1'b1, bytes[b][k], 1'b1, 1'b0);
        owe_state(1'b0, bytes[b][k], 1'b1, 1'b0);
      end
      // Ack clock with SDA released; the ack itself is never looked at.
      owe_state(1'b1, 1'b1, 1'b1, 1'b0);
      owe_state(1'b0, 1'b1, 1'b0, 1'b0);
    end
    // Stop: SCL rises with SDA low, then SDA rises.
    owe_state(1'b1, 1'b0, 1'b1, 1'b0);
    owe_state(1'b1, 1'b1, 1'b1, 1'b1);
  endfunction

  // Bias random bytes toward all-zero, all-one and walking-bit patterns.
  function automatic logic [7:0] pick_byte();
    logic [7:0] one_hot;
    one_hot = 8'h01 << $urandom_range(0, 7);
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one write on the input channel and hold it until it is taken.
  // Call at a falling edge; return at the falling edge after it is taken, with valid high.
  task automatic send_write(input logic [7:0] a, input logic d, input logic [7:0] p,
                            input logic use_wire, input logic [23:0] wire_bytes);
    int gap;
    if (burst_left == 0) begin
      // Start a new burst, mostly after a gap; now and then a long run with none.
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 80);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    dev_addr <= a;
    is_data  <= d;
    payload  <= p;
    do @(posedge clk); while (!in_ready);
    if (use_wire)
      expand_write(wire_bytes[23:16], wire_bytes[15:8], wire_bytes[7:0]);
    else
      expand_write(a, wire_control_byte(d), p);
    burst_left--;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed bus state has come out.
  task automatic pause_for_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_states.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Receiver: change ready at the falling edge, hopping between stall styles.
  initial begin : receiver
    rx_style_t style;
    int        style_left;
    int        tick;
    style      = RX_STREAM;
    style_left = 200;
    tick       = 0;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        style      = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(64, 400);
      end
      style_left--;
      tick++;
      case (style)
        RX_STREAM: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        RX_BLOCKS: out_ready <= ((tick % 48) < 16);
      endcase
    end
  end

  // Compare each bus state taken from the block with the oldest one owed.
  always @(posedge clk) begin : state_check
    bus_state_t got;
    bus_state_t want;
    if (!rst && out_valid && out_ready) begin
      got.scl  = scl;
      got.sda  = sda;
      got.hold = hold;
      got.last = last;
      if (pending_states.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected bus state scl=%b sda=%b hold=%b last=%b",
                   got.scl, got.sda, got.hold, got.last);
      end else begin
        want = pending_states.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda ||
            got.hold !== want.hold || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("write %0d state %0d: scl/sda/hold/last expected %b%b%b%b got %b%b%b%b",
                     states_seen / STATES_PER_WRITE, states_seen % STATES_PER_WRITE,
                     want.scl, want.sda, want.hold, want.last,
                     got.scl, got.sda, got.hold, got.last);
        end
        states_seen++;
      end
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[i2c_write_transaction_serializer_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    // Directed writes. Rows with typed wire bytes cover the extremes and the
    // two control codes; the rest lean on the predictor.
    directed_rows = '{
      '{8'h00, 1'b0, 8'h00, 1'b1, 24'h00_00_00},   // right after reset, all zero
      '{8'hFF, 1'b1, 8'hFF, 1'b1, 24'hFF_40_FF},
      '{8'hFF, 1'b0, 8'h00, 1'b1, 24'hFF_00_00},
      '{8'h00, 1'b1, 8'hFF, 1'b1, 24'h00_40_FF},
      '{8'hAA, 1'b1, 8'h55, 1'b1, 24'hAA_40_55},
      '{8'h55, 1'b0, 8'hAA, 1'b1, 24'h55_00_AA},
      '{8'h80, 1'b1, 8'h01, 1'b1, 24'h80_40_01},
      '{8'h01, 1'b0, 8'h80, 1'b1, 24'h01_00_80},
      '{8'h78, 1'b0, 8'hAE, 1'b0, 24'h0},          // typical display command
      '{8'h78, 1'b1, 8'h3C, 1'b0, 24'h0},
      '{8'h79, 1'b1, 8'h00, 1'b0, 24'h0},          // R/W bit set
      '{8'hFE, 1'b0, 8'h7F, 1'b0, 24'h0},
      '{8'h7F, 1'b1, 8'hFE, 1'b0, 24'h0},
      '{8'h3C, 1'b0, 8'hC3, 1'b0, 24'h0},
      '{8'hC3, 1'b1, 8'h3C, 1'b0, 24'h0},
      '{8'h0F, 1'b0, 8'hF0, 1'b0, 24'h0}
    };

    // Hold reset, then release it at a falling edge.
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r])
      send_write(directed_rows[r].addr, directed_rows[r].is_data,
                 directed_rows[r].payload, directed_rows[r].has_wire,
                 directed_rows[r].wire_bytes);

    // Let the block drain fully before the random part.
    pause_for_drain();

    for (int n = 0; n < RANDOM_WRITES; n++) begin
      // Drain now and then so writes also start from an idle pipeline.
      if (n % 100 == 50)
        pause_for_drain();
      send_write(pick_byte(), 1'($urandom_range(0, 1)), pick_byte(), 1'b0, 24'h0);
    end
    in_valid <= 1'b0;

    // Wait for every owed state, then wait out DRAIN_CYCLES for anything stray.
    while (pending_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_states.size() == 0)
      $display("[i2c_write_transaction_serializer_top] OK");
    else
      $display("[i2c_write_transaction_serializer_top] ERROR");
    $finish;
  end

endmodule
